>>> rtl/core/lmf_pkg.sv
// shared types, constants and helpers for the long message fragmenter
// no dependencies; used by lmf_div and long_message_fragmenter_core

package lmf_pkg;

    localparam int MSG_BYTES_DEF = 512;

    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd51;
    localparam logic [7:0] PAYLOAD_FLOOR   = 8'd8;
    localparam logic [7:0] PAYLOAD_KNEE    = 8'd200;
    localparam logic [7:0] PAYLOAD_DROP    = 8'd20;
    localparam logic [7:0] FRAME_OVERHEAD  = 8'd6;
    localparam logic [7:0] HDR_BYTES       = 8'd5;
    localparam logic [3:0] WORD_BYTES      = 4'd8;

    // register index on the configuration port
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_START   = 2'd1,
        CMD_OUTCOME = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // header byte positions in a frame
    localparam logic [7:0] POS_HDR  = 8'd0;
    localparam logic [7:0] POS_TAG  = 8'd1;
    localparam logic [7:0] POS_FRAG = 8'd2;
    localparam logic [7:0] POS_SEQ  = 8'd3;
    localparam logic [7:0] POS_LEN  = 8'd4;

    typedef struct packed {
        logic       start;
        logic [7:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic rem_nonzero;
    } div_stat_t;

    // data bytes per frame for a given payload limit
    function automatic logic [7:0] data_per_frame(input logic [7:0] max_payload);
        logic [7:0] lim;
        lim = (max_payload < PAYLOAD_FLOOR) ? PAYLOAD_FLOOR : max_payload;
        if (lim > PAYLOAD_KNEE)
        begin
            lim = lim - PAYLOAD_DROP;
        end
        return lim - FRAME_OVERHEAD;
    endfunction

endpackage

>>> rtl/core/lmf_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies

module lmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lmf_div.sv
// iterative restoring divider, one quotient bit per cycle, 8-bit divisor
// depends on lmf_pkg

module lmf_div #(
    parameter int DW = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lmf_pkg::div_req_t req,
    input  logic [DW-1:0]     dividend,
    output logic [DW-1:0]     quotient,
    output lmf_pkg::div_stat_t stat
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quot_reg, quot_next;
    logic [7:0]    rem_reg, rem_next;
    logic [7:0]    div_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [8:0]    trial;
    logic          ge;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[DW-1]};
        ge        = trial >= {1'b0, div_reg};
        rem_next  = ge ? 8'(trial - {1'b0, div_reg}) : trial[7:0];
        quot_next = {quot_reg[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quot_reg <= dividend;
                rem_reg  <= '0;
                div_reg  <= req.divisor;
                cnt_reg  <= CW'(DW);
            end
            else if (cnt_reg != '0)
            begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient         = quot_reg;
    assign stat.done        = done_reg;
    assign stat.rem_nonzero = rem_reg != 8'd0;

endmodule

>>> rtl/core/long_message_fragmenter_core.sv
// top level of the long message fragmenter: command sequencer, frame packer
// depends on lmf_pkg, lmf_ram, lmf_div
//
// Input stream s_*: one command per transfer, kind in s_tuser. A load writes
// one byte into the message store; a start latches length and tag and sends
// the first frame; a send outcome sends the next frame, repeats the current
// one with the retry bit set, or gives the done mark after the last frame.
// Output stream m_*: frames packed eight bytes per transfer, first byte in
// the low bits, m_tlast on the final word of each frame; the done mark is a
// single transfer with m_tuser high and no bytes.
// A frame is set up in ST_PREP; unless the whole message fits a frame, the
// divider then works out the fragment count one bit per cycle in ST_DIV.
// ST_EMIT packs the frame bytes into words and ST_OUT hands each word
// over. The store's single read port feeds one data byte per cycle while
// in ST_EMIT, pausing while a word waits in ST_OUT. s_tready is low while
// a frame or done mark is under way; a stall on m_tready holds the current
// word and the whole block until it is taken. Reset clears all message
// state and sets max_payload to 51; store contents are undefined until
// loaded.

module long_message_fragmenter_core #(
    parameter int MSG_BYTES = lmf_pkg::MSG_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // byte_address[8:0], byte_value[16:9], total_length[26:17],
    // magic[34:27], send_ok[35], zero fill [39:36]
    input  logic [39:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_bytes[63:0], byte_count[67:64], zero fill [71:68]
    output logic [71:0] m_tdata,
    // last_word
    output logic        m_tlast,
    // message_done[0]
    output logic        m_tuser,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MSG_BYTES);
    localparam int LW = $clog2(MSG_BYTES + 1);
    localparam logic [LW+9:0] MSG_WIDE = (LW + 10)'(MSG_BYTES);
    localparam logic [31:0]   MSG_32   = 32'(MSG_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_EMIT,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [7:0]    max_payload_reg;
    logic [LW-1:0] msg_len_reg;
    logic [LW-1:0] bytes_done_reg;
    logic [7:0]    seq_reg;
    logic          retry_reg;
    logic [7:0]    tag_reg;
    logic [7:0]    frag_len_reg;
    logic [7:0]    frags_left_reg;
    logic          busy_reg;
    logic [LW-1:0] offset_reg;
    logic [LW-1:0] rem_reg;
    logic [7:0]    pos_reg;
    logic [7:0]    sum_reg;
    logic          frame_end_reg;

    logic [63:0]   out_data_reg;
    logic [3:0]    out_count_reg;
    logic          out_last_reg;
    logic          out_done_reg;
    logic          out_valid_reg;

    // input fields
    logic [8:0] in_addr;
    logic [7:0] in_value;
    logic [9:0] in_tlen;
    logic [7:0] in_magic;
    logic       in_ok;
    logic       in_accept;

    assign in_addr   = s_tdata[8:0];
    assign in_value  = s_tdata[16:9];
    assign in_tlen   = s_tdata[26:17];
    assign in_magic  = s_tdata[34:27];
    assign in_ok     = s_tdata[35];
    assign s_tready  = state_reg == ST_IDLE;
    assign in_accept = s_tvalid && s_tready;

    // store write path
    logic [AW+8:0]  addr_wide;
    logic           ram_wen;
    logic [LW+9:0]  tlen_wide;
    logic [LW-1:0]  tlen_sat;

    assign addr_wide = {{AW{1'b0}}, in_addr};
    assign ram_wen   = in_accept && (s_tuser == lmf_pkg::CMD_LOAD)
                       && ({23'd0, in_addr} < MSG_32);
    assign tlen_wide = {{LW{1'b0}}, in_tlen};
    assign tlen_sat  = (tlen_wide > MSG_WIDE) ? LW'(MSG_BYTES) : tlen_wide[LW-1:0];

    // store read path, one data byte per emit cycle
    logic [15:0]   raddr_wide;
    logic [7:0]    ram_rdata;

    assign raddr_wide = 16'(offset_reg) + 16'(pos_reg) - 16'(lmf_pkg::POS_LEN);

    lmf_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_store (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (addr_wide[AW-1:0]),
        .wdata (in_value),
        .ren   (state_reg == ST_EMIT),
        .raddr (raddr_wide[AW-1:0]),
        .rdata (ram_rdata)
    );

    // fragment sizing
    logic [7:0]    per;
    logic [LW-1:0] rem_calc;
    logic          fits;
    logic [15:0]   total16;
    logic [15:0]   rem16;
    logic [7:0]    len_split;
    logic [15:0]   frag_calc;

    lmf_pkg::div_req_t  div_req;
    lmf_pkg::div_stat_t div_stat;
    logic [LW-1:0]      div_quot;

    assign per       = lmf_pkg::data_per_frame(max_payload_reg);
    assign rem_calc  = (bytes_done_reg > msg_len_reg) ? '0 : msg_len_reg - bytes_done_reg;
    assign total16   = 16'(msg_len_reg);
    assign rem16     = 16'(rem_reg);
    assign fits      = total16 <= 16'(per);
    assign len_split = (rem16 < 16'(per)) ? rem16[7:0] : per;
    assign frag_calc = 16'(div_quot) + 16'(div_stat.rem_nonzero) - 16'd1;

    assign div_req.start   = (state_reg == ST_PREP) && !fits;
    assign div_req.divisor = per;

    lmf_div #(
        .DW (LW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (rem_calc),
        .quotient  (div_quot),
        .stat      (div_stat)
    );

    // frame byte selection and packing
    logic [7:0]  last_pos;
    logic        is_last;
    logic [7:0]  frame_byte;
    logic [63:0] data_ins;
    logic [3:0]  count_inc;
    logic        flush;
    logic [15:0] bytes_done_sum;

    always_comb
    begin
        last_pos = frag_len_reg + lmf_pkg::HDR_BYTES;
        is_last  = pos_reg == last_pos;
        case (pos_reg)
            lmf_pkg::POS_HDR:  frame_byte = {6'd0, retry_reg, 1'b1};
            lmf_pkg::POS_TAG:  frame_byte = tag_reg;
            lmf_pkg::POS_FRAG: frame_byte = frags_left_reg;
            lmf_pkg::POS_SEQ:  frame_byte = seq_reg;
            lmf_pkg::POS_LEN:  frame_byte = frag_len_reg;
            default:           frame_byte = is_last ? sum_reg : ram_rdata;
        endcase
        data_ins  = out_data_reg | (64'(frame_byte) << {out_count_reg[2:0], 3'b000});
        count_inc = out_count_reg + 4'd1;
        flush     = (count_inc == lmf_pkg::WORD_BYTES) || is_last;
        bytes_done_sum = 16'(bytes_done_reg) + 16'(frag_len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            msg_len_reg    <= '0;
            bytes_done_reg <= '0;
            seq_reg        <= '0;
            retry_reg      <= 1'b0;
            tag_reg        <= '0;
            frag_len_reg   <= '0;
            frags_left_reg <= '0;
            busy_reg       <= 1'b0;
            offset_reg     <= '0;
            rem_reg        <= '0;
            pos_reg        <= '0;
            sum_reg        <= '0;
            frame_end_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_done_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (s_tuser)
                            lmf_pkg::CMD_START:
                            begin
                                msg_len_reg    <= tlen_sat;
                                bytes_done_reg <= '0;
                                seq_reg        <= 8'd1;
                                retry_reg      <= 1'b0;
                                tag_reg        <= in_magic;
                                busy_reg       <= 1'b1;
                                state_reg      <= ST_PREP;
                            end
                            lmf_pkg::CMD_OUTCOME:
                            begin
                                if (busy_reg)
                                begin
                                    if (!in_ok)
                                    begin
                                        retry_reg <= 1'b1;
                                        state_reg <= ST_PREP;
                                    end
                                    else if (frags_left_reg == 8'd0)
                                    begin
                                        // done mark, no bytes
                                        busy_reg      <= 1'b0;
                                        out_data_reg  <= '0;
                                        out_count_reg <= '0;
                                        out_last_reg  <= 1'b0;
                                        out_done_reg  <= 1'b1;
                                        out_valid_reg <= 1'b1;
                                        frame_end_reg <= 1'b1;
                                        state_reg     <= ST_OUT;
                                    end
                                    else
                                    begin
                                        retry_reg      <= 1'b0;
                                        seq_reg        <= seq_reg + 8'd1;
                                        bytes_done_reg <= bytes_done_sum[LW-1:0];
                                        state_reg      <= ST_PREP;
                                    end
                                end
                            end
                            default:
                            begin
                                // loads go straight to the store, unused code ignored
                            end
                        endcase
                    end
                end
                ST_PREP:
                begin
                    pos_reg       <= '0;
                    sum_reg       <= '0;
                    out_data_reg  <= '0;
                    out_count_reg <= '0;
                    rem_reg       <= rem_calc;
                    if (fits)
                    begin
                        // whole message in one frame
                        frags_left_reg <= 8'd0;
                        offset_reg     <= '0;
                        frag_len_reg   <= total16[7:0];
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        offset_reg <= bytes_done_reg;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        frags_left_reg <= frag_calc[7:0];
                        frag_len_reg   <= len_split;
                        state_reg      <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    out_data_reg  <= data_ins;
                    out_count_reg <= count_inc;
                    sum_reg       <= sum_reg + frame_byte;
                    pos_reg       <= pos_reg + 8'd1;
                    if (flush)
                    begin
                        out_last_reg  <= is_last;
                        out_done_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                        frame_end_reg <= is_last;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        out_data_reg  <= '0;
                        out_count_reg <= '0;
                        out_last_reg  <= 1'b0;
                        out_done_reg  <= 1'b0;
                        state_reg     <= frame_end_reg ? ST_IDLE : ST_EMIT;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_count_reg, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

    // configuration port
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= lmf_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_write && (paddr[2] == lmf_pkg::REG_MAX_PAYLOAD))
        begin
            max_payload_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == lmf_pkg::REG_MAX_PAYLOAD) ? {24'd0, max_payload_reg} : 32'd0;

endmodule

>>> dv/tb_long_message_fragmenter_core.sv
// testbench for long_message_fragmenter_core: drives load, start and outcome commands,
// predicts every frame word and done mark, and checks them as they leave the block
// depends on lmf_pkg and the long_message_fragmenter_core rtl
`timescale 1ns / 100ps

module tb_long_message_fragmenter_core;

    localparam int unsigned STORE_DEPTH   = 512;
    localparam int unsigned RANDOM_ITEMS  = 400;
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam logic [2:0]  PAYLOAD_REG_ADDR    = {lmf_pkg::REG_MAX_PAYLOAD, 2'b00};
    localparam logic [7:0]  PAYLOAD_AFTER_RESET = 8'd51;

    typedef struct {
        logic [63:0] frame_bytes;
        logic [3:0]  byte_count;
        logic        last_word;
        logic        message_done;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // byte_address[8:0], byte_value[16:9], total_length[26:17], magic[34:27], send_ok[35]
    logic [39:0] s_tdata;
    // cmd[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // frame_bytes[63:0], byte_count[67:64]
    logic [71:0] m_tdata;
    logic        m_tlast;
    // message_done[0]
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // fragmenter state as the block should hold it
    logic [7:0]  msg_store [STORE_DEPTH];
    bit          store_written [STORE_DEPTH];
    int unsigned loaded_upto;
    int unsigned msg_len;
    int unsigned sent_bytes;
    logic [7:0]  seq_num;
    logic [7:0]  frag_len;
    logic [7:0]  frags_left;
    logic [7:0]  msg_tag;
    logic        retry_flag;
    bit          in_message;
    logic [7:0]  payload_limit;

    out_word_t   expected_words[$];

    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned items_counted;
    int unsigned payload_writes;
    int unsigned words_checked;
    int unsigned frames_checked;
    int unsigned done_marks;
    bit          no_gaps;

    long_message_fragmenter_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("long_message_fragmenter_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("cycle %0d: mismatch on %s, got %h want %h", cycle_count, what, got, want);
        end
    endtask

    function automatic int unsigned frame_data_room();
        int unsigned lim;
        lim = payload_limit;
        if (lim < 8)
        begin
            lim = 8;
        end
        if (lim > 200)
        begin
            lim = lim - 20;
        end
        return lim - 6;
    endfunction

    // builds the current frame and queues it as packed words
    function automatic void pack_frame_words();
        logic [7:0]  fb [256];
        int unsigned per;
        int unsigned rem;
        int unsigned cnt;
        int unsigned offset;
        int unsigned len;
        int unsigned n;
        int unsigned sum;
        int unsigned words;
        int unsigned nb;
        out_word_t   w;
        per = frame_data_room();
        if (msg_len <= per)
        begin
            frags_left = 8'd0;
            offset = 0;
            len = msg_len;
        end
        else
        begin
            rem = (sent_bytes > msg_len) ? 0 : msg_len - sent_bytes;
            cnt = (rem + per - 1) / per;
            frags_left = 8'(cnt - 1);
            offset = sent_bytes;
            len = (rem < per) ? rem : per;
        end
        frag_len = 8'(len);
        fb[0] = {6'b0, retry_flag, 1'b1};
        fb[1] = msg_tag;
        fb[2] = frags_left;
        fb[3] = seq_num;
        fb[4] = frag_len;
        n = 5;
        for (int unsigned i = 0; i < len; i++)
        begin
            fb[n] = (offset + i < STORE_DEPTH) ? msg_store[offset + i] : 8'h00;
            n++;
        end
        sum = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            sum += fb[i];
        end
        fb[n] = 8'(sum);
        n++;
        words = (n + 7) / 8;
        for (int unsigned i = 0; i < words; i++)
        begin
            w.frame_bytes = '0;
            nb = n - i * 8;
            if (nb > 8)
            begin
                nb = 8;
            end
            for (int unsigned k = 0; k < nb; k++)
            begin
                w.frame_bytes[8 * k +: 8] = fb[i * 8 + k];
            end
            w.byte_count = 4'(nb);
            w.last_word = (i + 1 == words);
            w.message_done = 1'b0;
            expected_words.push_back(w);
        end
    endfunction

    function automatic void track_command(input lmf_pkg::cmd_t c, input logic [8:0] addr,
                                          input logic [7:0] val, input logic [9:0] tlen,
                                          input logic [7:0] tag, input logic ok);
        out_word_t mark;
        case (c)
            lmf_pkg::CMD_LOAD:
            begin
                items_counted++;
                msg_store[addr] = val;
                store_written[addr] = 1'b1;
                while (loaded_upto < STORE_DEPTH && store_written[loaded_upto])
                begin
                    loaded_upto++;
                end
            end
            lmf_pkg::CMD_START:
            begin
                items_counted++;
                msg_len = (tlen > STORE_DEPTH) ? STORE_DEPTH : tlen;
                sent_bytes = 0;
                seq_num = 8'd1;
                retry_flag = 1'b0;
                msg_tag = tag;
                in_message = 1'b1;
                pack_frame_words();
            end
            lmf_pkg::CMD_OUTCOME:
            begin
                if (in_message)
                begin
                    items_counted++;
                    if (!ok)
                    begin
                        retry_flag = 1'b1;
                        pack_frame_words();
                    end
                    else if (frags_left == 8'd0)
                    begin
                        in_message = 1'b0;
                        mark.frame_bytes = '0;
                        mark.byte_count = 4'd0;
                        mark.last_word = 1'b0;
                        mark.message_done = 1'b1;
                        expected_words.push_back(mark);
                    end
                    else
                    begin
                        retry_flag = 1'b0;
                        seq_num = seq_num + 8'd1;
                        sent_bytes = sent_bytes + frag_len;
                        pack_frame_words();
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // called and returns at a falling edge; tvalid is left high for a following transfer
    task automatic send_item(input lmf_pkg::cmd_t c, input logic [8:0] addr,
                             input logic [7:0] val, input logic [9:0] tlen,
                             input logic [7:0] tag, input logic ok);
        while (!no_gaps && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {4'b0, ok, tag, tlen, val, addr};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        track_command(c, addr, val, tlen, tag, ok);
        @(negedge clk);
    endtask

    task automatic load_byte(input logic [8:0] addr, input logic [7:0] val);
        send_item(lmf_pkg::CMD_LOAD, addr, val, 10'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic start_message(input logic [9:0] len, input logic [7:0] tag);
        send_item(lmf_pkg::CMD_START, 9'($urandom), 8'($urandom), len, tag, 1'($urandom));
    endtask

    task automatic send_outcome(input logic ok);
        send_item(lmf_pkg::CMD_OUTCOME, 9'($urandom), 8'($urandom), 10'($urandom),
                  8'($urandom), ok);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_read(output logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= PAYLOAD_REG_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write then read back; psel stays high into the read setup
    task automatic set_payload_limit(input logic [7:0] value);
        logic [31:0] readback;
        wait_results_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PAYLOAD_REG_ADDR;
        pwdata <= {24'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        payload_limit = value;
        payload_writes++;
        @(negedge clk);
        apb_read(readback);
        if (readback !== {24'h0, payload_limit})
        begin
            report_mismatch("max_payload readback", 64'(readback), 64'(payload_limit));
        end
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(9))
            0: return 8'd8;
            1: return 8'd255;
            2: return 8'd200;
            3: return 8'd201;
            4: return 8'($urandom_range(7));
            default: return 8'($urandom_range(80, 8));
        endcase
    endfunction

    // never longer than the loaded prefix, so no unwritten entry is read
    function automatic logic [9:0] pick_message_length();
        int unsigned cap;
        cap = (loaded_upto < 120) ? loaded_upto : 120;
        case ($urandom_range(7))
            0: return 10'd0;
            1: return 10'(loaded_upto);
            default: return 10'($urandom_range(cap));
        endcase
    endfunction

    task automatic check_word();
        out_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("word with nothing pending", m_tdata[63:0], 64'h0);
        end
        else
        begin
            want = expected_words.pop_front();
            words_checked++;
            if (m_tdata[63:0] !== want.frame_bytes)
            begin
                report_mismatch("frame_bytes", m_tdata[63:0], want.frame_bytes);
            end
            if (m_tdata[67:64] !== want.byte_count)
            begin
                report_mismatch("byte_count", 64'(m_tdata[67:64]), 64'(want.byte_count));
            end
            if (m_tlast !== want.last_word)
            begin
                report_mismatch("last_word", 64'(m_tlast), 64'(want.last_word));
            end
            if (m_tuser !== want.message_done)
            begin
                report_mismatch("message_done", 64'(m_tuser), 64'(want.message_done));
            end
            if (want.message_done)
            begin
                done_marks++;
            end
            else if (want.last_word)
            begin
                frames_checked++;
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                check_word();
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    task automatic test_directed_cases();
        logic [31:0] readback;
        apb_read(readback);
        if (readback !== {24'h0, PAYLOAD_AFTER_RESET})
        begin
            report_mismatch("max_payload after reset", 64'(readback), 64'(PAYLOAD_AFTER_RESET));
        end
        // unused command and an outcome with no message both pass silently
        send_item(lmf_pkg::CMD_UNUSED, 9'h1FF, 8'hFF, 10'h3FF, 8'hFF, 1'b1);
        send_outcome(1'b1);
        for (int unsigned i = 0; i < 12; i++)
        begin
            load_byte(9'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
        end
        load_byte(9'h1FF, 8'hFF);
        // empty message: header and checksum only
        start_message(10'd0, 8'h00);
        send_outcome(1'b1);
        // single frame with a retry
        start_message(10'd12, 8'hFF);
        send_outcome(1'b0);
        send_outcome(1'b1);
        // restart while a message is in flight
        start_message(10'd5, 8'h3C);
        start_message(10'd12, 8'hC3);
        send_outcome(1'b1);
    endtask

    task automatic test_payload_change_mid_message();
        set_payload_limit(8'd8);
        start_message(10'd12, 8'h5A);
        send_outcome(1'b1);
        send_outcome(1'b0);
        send_outcome(1'b1);
        set_payload_limit(8'd13);
        send_outcome(1'b0);
        while (in_message)
        begin
            send_outcome(1'b1);
        end
    endtask

    task automatic test_random_messages();
        int unsigned first_item;
        int unsigned new_bytes;
        int unsigned r;
        bit          abandon;
        first_item = items_counted;
        while (items_counted - first_item < RANDOM_ITEMS)
        begin
            if ($urandom_range(3) == 0)
            begin
                set_payload_limit(pick_payload());
            end
            new_bytes = $urandom_range(48);
            for (int unsigned i = 0; i < new_bytes && loaded_upto < STORE_DEPTH; i++)
            begin
                load_byte(9'(loaded_upto), 8'($urandom));
            end
            repeat ($urandom_range(3)) load_byte(9'($urandom), 8'($urandom));
            start_message(pick_message_length(), 8'($urandom));
            abandon = 1'b0;
            while (in_message && !abandon)
            begin
                r = $urandom_range(99);
                if (r < 3)
                begin
                    abandon = 1'b1;
                end
                else if (r < 6)
                begin
                    load_byte(9'($urandom), 8'($urandom));
                end
                else if (r < 8)
                begin
                    send_item(lmf_pkg::CMD_UNUSED, 9'($urandom), 8'($urandom), 10'($urandom),
                              8'($urandom), 1'($urandom));
                end
                else if (r < 10)
                begin
                    start_message(pick_message_length(), 8'($urandom));
                end
                else if (r < 12)
                begin
                    set_payload_limit(pick_payload());
                end
                else
                begin
                    send_outcome($urandom_range(99) >= 20);
                end
            end
        end
    endtask

    task automatic test_full_store_wrap();
        logic [7:0] limits [3];
        limits[0] = 8'd255;
        limits[1] = 8'd201;
        limits[2] = 8'd200;
        while (loaded_upto < STORE_DEPTH)
        begin
            load_byte(9'(loaded_upto), 8'($urandom));
        end
        // two data bytes per frame over a saturated length: 256 frames, sequence wraps
        set_payload_limit(8'd3);
        no_gaps = 1'b1;
        start_message(10'h3FF, 8'($urandom));
        while (in_message)
        begin
            send_outcome(1'b1);
        end
        no_gaps = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            set_payload_limit(limits[i]);
            start_message(10'(STORE_DEPTH + $urandom_range(511)), 8'($urandom));
            while (in_message)
            begin
                send_outcome($urandom_range(99) >= 25);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_gaps = 1'b0;
        fail_count = 0;
        items_sent = 0;
        items_counted = 0;
        payload_writes = 0;
        words_checked = 0;
        frames_checked = 0;
        done_marks = 0;
        loaded_upto = 0;
        msg_len = 0;
        sent_bytes = 0;
        seq_num = 8'd0;
        frag_len = 8'd0;
        frags_left = 8'd0;
        msg_tag = 8'd0;
        retry_flag = 1'b0;
        in_message = 1'b0;
        payload_limit = PAYLOAD_AFTER_RESET;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            store_written[i] = 1'b0;
            msg_store[i] = 8'h00;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_payload_change_mid_message();
        test_random_messages();
        test_full_store_wrap();
        wait_results_drained();

        $display("sent %0d command transfers (%0d acted on) across %0d payload limit writes",
                 items_sent, items_counted, payload_writes);
        $display("checked %0d output transfers: %0d frames, %0d done marks",
                 words_checked, frames_checked, done_marks);
        if (fail_count == 0)
        begin
            $display("long_message_fragmenter_core verification clean");
        end
        else
        begin
            $display("long_message_fragmenter_core verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lmf_pkg.sv
rtl/core/lmf_ram.sv
rtl/core/lmf_div.sv
rtl/core/long_message_fragmenter_core.sv
dv/tb_long_message_fragmenter_core.sv
